FILE: hdl/dtp_pkg.sv
// shared types and constants of the decimal text parser
`default_nettype none

package dtp_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int VALUE_BITS         = 32;
   localparam int STATUS_BITS        = 2;
   localparam int CONSUMED_BITS      = 16;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_BACKSLASH = 8'd92;
   localparam logic [7:0] CH_PLUS      = 8'd43;
   localparam logic [7:0] CH_MINUS     = 8'd45;
   localparam logic [7:0] CH_ZERO      = 8'd48;
   localparam logic [7:0] CH_NINE      = 8'd57;
   localparam logic [7:0] CH_HIGH_MIN  = 8'd128;
   localparam logic [7:0] CH_HIGH_MAX  = 8'd255;

   localparam logic [VALUE_BITS-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [VALUE_BITS-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [2:0] {
      PH_DONE   = 3'd0,
      PH_SKIP   = 3'd1,
      PH_PLUS   = 3'd2,
      PH_MINUS  = 3'd3,
      PH_DIGITS = 3'd4
   } phase_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FALLBACK   = 1'd0,
      CSR_SKIP_SPACE = 1'd1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: hdl/dtp_channels.sv
// valid/ready channel interfaces of the decimal text parser
`default_nettype none

interface dtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, text_byte, first_byte, last_byte, input ready);
   modport sink (input valid, text_byte, first_byte, last_byte, output ready);
endinterface

interface dtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] parsed_value;
   logic [1:0]  parse_status;
   logic [15:0] bytes_consumed;

   modport source (output valid, parsed_value, parse_status, bytes_consumed, input ready);
   modport sink (input valid, parsed_value, parse_status, bytes_consumed, output ready);
endinterface

interface dtp_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  reg_index;
   logic [31:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/decimal_int_text_parser_top.sv
// decimal text to signed 32-bit integer parser, one byte per cycle unless rsp_bus stalls
//
//  channel   modport  payload                                       transfer
//  req_bus   sink     text_byte, first_byte, last_byte              one text byte
//  rsp_bus   source   parsed_value, parse_status, bytes_consumed    one parse result
//  csr_bus   sink     reg_index, wdata                              one register write
//
//  one byte per cycle sustained unless rsp_bus stalls; a byte is held in the input register,
//  and its result (if any) then lands in the output register
//  the digit step is one shift-add times ten and a 36-bit compare
//  synchronous reset clears parse state, both valid flags and fallback; sets skip on
//  a stalled result holds the pipe: req_bus.ready drops only while rsp_bus is full
//  and not taken; csr writes are always ready
`default_nettype none

module decimal_int_text_parser_top
   import dtp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dtp_req_if.sink    req_bus,
   dtp_rsp_if.source  rsp_bus,
   dtp_csr_if.sink    csr_bus
);

   localparam int ACC_BITS  = VALUE_BITS + 4;
   localparam int WIDE_BITS = 33;

   // configuration
   logic [VALUE_BITS-1:0] fallback_ff, fallback_in;
   logic                  skip_ff, skip_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   // parse state
   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  ovf_ff, ovf_in;
   logic                  seen_ff, seen_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] cbn_ff, cbn_in;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]    out_value_ff, out_value_in;
   status_type               out_status_ff, out_status_in;
   logic [CONSUMED_BITS-1:0] out_count_ff, out_count_in;

   logic advance;
   logic take;
   logic emit;

   assign advance     = !out_valid_ff || rsp_bus.ready;
   assign take        = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in = (req_bus.valid && req_bus.ready) || (in_valid_ff && !advance);

   assign csr_bus.ready = 1'b1;

   always_comb begin
      fallback_in = fallback_ff;
      skip_in     = skip_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_FALLBACK:   fallback_in = csr_bus.wdata;
            CSR_SKIP_SPACE: skip_in     = csr_bus.wdata[0];
            default:        ;
         endcase
      end
   end

   // byte step
   logic                  is_sep, is_plus, is_minus, is_digit;
   logic                  consumed;
   logic                  stage_plus, stage_minus;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [ACC_BITS-1:0]   acc;
   logic [ACC_BITS-1:0]   limit;
   logic [WIDE_BITS-1:0]  cnt_wide;
   logic [COUNT_BITS-1:0] cnt_sel;

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      ovf_in    = ovf_ff;
      seen_in   = seen_ff;
      cnt_in    = cnt_ff;
      cbn_in    = cbn_ff;
      consumed  = 1'b0;
      emit      = 1'b0;
      is_sep    = in_byte_ff inside {[8'd0:CH_SPACE], [CH_HIGH_MIN:CH_HIGH_MAX], CH_BACKSLASH};
      is_plus   = in_byte_ff == CH_PLUS;
      is_minus  = in_byte_ff == CH_MINUS;
      is_digit  = in_byte_ff inside {[CH_ZERO:CH_NINE]};
      stage_plus  = 1'b0;
      stage_minus = 1'b0;

      if (in_first_ff) begin
         neg_in   = 1'b0;
         mag_in   = '0;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         cnt_in   = '0;
         cbn_in   = '0;
         phase_in = skip_ff ? PH_SKIP : PH_PLUS;
      end

      cnt_inc = (cnt_in == '1) ? cnt_in : cnt_in + COUNT_BITS'(1);
      limit   = neg_in ? ACC_BITS'(NEG_LIMIT) : ACC_BITS'(POS_LIMIT);
      acc     = {1'b0, mag_in, 3'b000} + {3'b000, mag_in, 1'b0}
              + ACC_BITS'(in_byte_ff - CH_ZERO);

      if (phase_in != PH_DONE) begin
         if (phase_in == PH_SKIP && is_sep) begin
            consumed = 1'b1;
            cbn_in   = cnt_inc;
         end else begin
            stage_plus = (phase_in == PH_SKIP) || (phase_in == PH_PLUS);
            if (stage_plus && is_plus) begin
               consumed = 1'b1;
               cbn_in   = cnt_inc;
               phase_in = PH_MINUS;
            end else begin
               stage_minus = stage_plus || (phase_in == PH_MINUS);
               if (stage_minus && is_minus) begin
                  consumed = 1'b1;
                  neg_in   = 1'b1;
                  phase_in = PH_DIGITS;
               end else if (is_digit) begin
                  consumed = 1'b1;
                  seen_in  = 1'b1;
                  phase_in = PH_DIGITS;
                  if (!ovf_in) begin
                     if (acc > limit) begin
                        ovf_in = 1'b1;
                     end else begin
                        mag_in = acc[VALUE_BITS-1:0];
                     end
                  end
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         if (consumed) begin
            cnt_in = cnt_inc;
            if (in_last_ff) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end
      end
      emit = emit && in_valid_ff;

      // result
      if (!seen_in) begin
         out_value_in  = fallback_ff;
         out_status_in = STATUS_NO_DIGITS;
         cnt_sel       = cbn_in;
      end else if (ovf_in) begin
         out_value_in  = fallback_ff;
         out_status_in = STATUS_RANGE;
         cnt_sel       = cnt_in;
      end else begin
         out_value_in  = neg_in ? (VALUE_BITS'(0) - mag_in) : mag_in;
         out_status_in = STATUS_OK;
         cnt_sel       = cnt_in;
      end
      cnt_wide     = WIDE_BITS'(cnt_sel);
      out_count_in = (cnt_wide > WIDE_BITS'({CONSUMED_BITS{1'b1}})) ?
                     {CONSUMED_BITS{1'b1}} : cnt_wide[CONSUMED_BITS-1:0];
   end

   assign out_valid_in = (take && emit) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff  <= '0;
         skip_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_DONE;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         cnt_ff       <= '0;
         cbn_ff       <= '0;
      end else begin
         fallback_ff  <= fallback_in;
         skip_ff      <= skip_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            ovf_ff   <= ovf_in;
            seen_ff  <= seen_in;
            cnt_ff   <= cnt_in;
            cbn_ff   <= cbn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff  <= req_bus.text_byte;
         in_first_ff <= req_bus.first_byte;
         in_last_ff  <= req_bus.last_byte;
      end
      if (take && emit) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
         out_count_ff  <= out_count_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.parsed_value   = out_value_ff;
   assign rsp_bus.parse_status   = out_status_ff;
   assign rsp_bus.bytes_consumed = out_count_ff;

   // no result from a byte that arrives after the parse is over
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff != PH_DONE || in_first_ff))
      else $error("result from a byte outside a parse");

   // a good number always consumed at least one digit
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == STATUS_OK) |-> out_count_ff != '0)
      else $error("ok result with zero bytes consumed");

   // sign is only taken once the sign phases are behind
   assert property (@(posedge clock) disable iff (reset)
      neg_ff |-> (phase_ff != PH_SKIP && phase_ff != PH_PLUS && phase_ff != PH_MINUS))
      else $error("minus sign recorded too early");

   // magnitude stays within the positive range unless negative
   assert property (@(posedge clock) disable iff (reset)
      !neg_ff |-> mag_ff <= POS_LIMIT)
      else $error("positive magnitude above limit");

   // a full output register that is not taken blocks the pipe
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && in_valid_ff) |=> $stable(phase_ff))
      else $error("parse state moved during a stall");

endmodule

`default_nettype wire
